// File: rtl/core/qau_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and helper functions of the quaternion unit.
package qau_pkg;

  localparam int DW       = 32;              // component width
  localparam int FB       = 28;              // fraction bits
  localparam int PW       = 2 * DW;          // full product width
  localparam int AW       = PW + 3 - FB;     // sum of four rounded products
  localparam int SW       = 2 * DW + 1;      // sum of four squares
  localparam int SQ_STEPS = (SW + 1) / 2;    // root bits
  localparam int NW       = DW + 2 * FB;     // widest dividend
  localparam int QB       = DW;              // quotient bits below overflow
  localparam int TW       = SW + QB;         // shifted divisor width
  localparam int LAT_NORM = 2 + SQ_STEPS + 1 + QB + 2;
  localparam int LAT      = LAT_NORM + 1;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_NEG   = 4'd2;
  localparam logic [3:0] OP_CONJ  = 4'd3;
  localparam logic [3:0] OP_SCALE = 4'd4;
  localparam logic [3:0] OP_PROD  = 4'd5;
  localparam logic [3:0] OP_ROT   = 4'd6;
  localparam logic [3:0] OP_NORM  = 4'd7;
  localparam logic [3:0] OP_INV   = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // Index 0 is the real part, then i, j, k.
  typedef logic [3:0][DW-1:0] quat_t;

  typedef struct packed {
    logic [3:0]           req_type;
    logic signed [DW-1:0] a_w;
    logic signed [DW-1:0] a_x;
    logic signed [DW-1:0] a_y;
    logic signed [DW-1:0] a_z;
    logic signed [DW-1:0] b_w;
    logic signed [DW-1:0] b_x;
    logic signed [DW-1:0] b_y;
    logic signed [DW-1:0] b_z;
    logic signed [DW-1:0] scale_k;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] res_w;
    logic signed [DW-1:0] res_x;
    logic signed [DW-1:0] res_y;
    logic signed [DW-1:0] res_z;
    logic [1:0]           status;
  } rsp_t;

  typedef struct packed {
    logic sat;
    logic zero;
  } norm_stat_t;

  function automatic logic signed [AW-1:0] sx(input logic [DW-1:0] v);
    return AW'($signed(v));
  endfunction

  // Returns the saturation flag above the clamped component.
  function automatic logic [DW:0] sat_acc(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return {1'b1, hi[DW-1:0]};
    end else if (x < lo) begin
      return {1'b1, lo[DW-1:0]};
    end
    return {1'b0, x[DW-1:0]};
  endfunction

  // Sign of term a[i]*b[i^r] in component r of the Hamilton product.
  function automatic logic neg_term(input logic [1:0] r, input logic [1:0] i);
    return (r == 2'd0 && i != 2'd0) || (r == 2'd1 && i == 2'd3) ||
           (r == 2'd2 && i == 2'd1) || (r == 2'd3 && i == 2'd2);
  endfunction

endpackage

// File: rtl/core/quaternion_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Every operation passes through the full pipeline from an accepted request to its response.
// Throughput: one request per cycle while no response is stalled; the 33-step square root and the 32-step
// per-component divider of the normalize/inverse path set the pipeline depth.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits of all stages; data registers are not reset.
module quaternion_arithmetic_unit_core import qau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SHORT_STAGE = 7;

  logic            adv;
  logic [LAT:1]    vld;
  logic [3:0]      op_pipe [1:LAT_NORM];

  quat_t           req_a;
  quat_t           req_b;
  quat_t           q1_b;
  quat_t           misc_c;
  logic            misc_fc;

  quat_t           a_pipe     [1:3];
  quat_t           misc_pipe  [1:6];
  logic            misc_fpipe [1:6];
  quat_t           q1_pipe    [4:6];
  logic            q1_fpipe   [4:6];
  rsp_t            short_pipe [SHORT_STAGE:LAT_NORM];
  rsp_t            short_c;
  rsp_t            out_c;

  quat_t           q1_res;
  logic            q1_flag;
  quat_t           q2_res;
  logic            q2_flag;
  quat_t           nm_res;
  norm_stat_t      nm_stat;

  assign adv       = !(vld[LAT] && rsp_stall);
  assign req_stall = !adv;
  assign rsp_valid = vld[LAT];

  assign req_a = {req.a_z, req.a_y, req.a_x, req.a_w};
  assign req_b = {req.b_z, req.b_y, req.b_x, req.b_w};
  // Scaling is a product with the pure real quaternion (k, 0, 0, 0).
  assign q1_b  = (req.req_type == OP_SCALE) ? {{(3*DW){1'b0}}, req.scale_k} : req_b;

  always_comb begin
    logic signed [AW-1:0] v;
    logic [DW:0]          s;
    misc_fc = 1'b0;
    for (int i = 0; i < 4; i++) begin
      case (req.req_type)
        OP_ADD:  v = sx(req_a[i]) + sx(req_b[i]);
        OP_SUB:  v = sx(req_a[i]) - sx(req_b[i]);
        OP_NEG:  v = -sx(req_a[i]);
        OP_CONJ: v = (i == 0) ? sx(req_a[i]) : -sx(req_a[i]);
        default: v = '0;
      endcase
      s         = sat_acc(v);
      misc_c[i] = s[DW-1:0];
      misc_fc   = misc_fc | s[DW];
    end
  end

  qau_qmul u_qmul_ab (
    .clk    (clk),
    .en     (adv),
    .conj_b (1'b0),
    .a      (req_a),
    .b      (q1_b),
    .res    (q1_res),
    .flag   (q1_flag)
  );

  qau_qmul u_qmul_rot (
    .clk    (clk),
    .en     (adv),
    .conj_b (1'b1),
    .a      (q1_res),
    .b      (a_pipe[3]),
    .res    (q2_res),
    .flag   (q2_flag)
  );

  qau_norm u_norm (
    .clk  (clk),
    .en   (adv),
    .a    (req_a),
    .inv  (req.req_type == OP_INV),
    .res  (nm_res),
    .stat (nm_stat)
  );

  always_comb begin
    quat_t q;
    logic  f;
    case (op_pipe[6]) inside
      OP_ADD, OP_SUB, OP_NEG, OP_CONJ: begin
        q = misc_pipe[6];
        f = misc_fpipe[6];
      end
      OP_SCALE, OP_PROD: begin
        q = q1_pipe[6];
        f = q1_fpipe[6];
      end
      OP_ROT: begin
        q = q2_res;
        f = q1_fpipe[6] | q2_flag;
      end
      default: begin
        q = '0;
        f = 1'b0;
      end
    endcase
    short_c.res_w  = q[0];
    short_c.res_x  = q[1];
    short_c.res_y  = q[2];
    short_c.res_z  = q[3];
    short_c.status = f ? ST_SAT : ST_OK;
  end

  always_comb begin
    case (op_pipe[LAT_NORM]) inside
      OP_NORM, OP_INV: begin
        out_c.res_w  = nm_res[0];
        out_c.res_x  = nm_res[1];
        out_c.res_y  = nm_res[2];
        out_c.res_z  = nm_res[3];
        out_c.status = nm_stat.zero ? ST_ZERO : (nm_stat.sat ? ST_SAT : ST_OK);
      end
      default: out_c = short_pipe[LAT_NORM];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_pipe[1] <= req.req_type;
      for (int k = 2; k <= LAT_NORM; k++) begin
        op_pipe[k] <= op_pipe[k-1];
      end
      a_pipe[1] <= req_a;
      for (int k = 2; k <= 3; k++) begin
        a_pipe[k] <= a_pipe[k-1];
      end
      misc_pipe[1]  <= misc_c;
      misc_fpipe[1] <= misc_fc;
      for (int k = 2; k <= 6; k++) begin
        misc_pipe[k]  <= misc_pipe[k-1];
        misc_fpipe[k] <= misc_fpipe[k-1];
      end
      q1_pipe[4]  <= q1_res;
      q1_fpipe[4] <= q1_flag;
      for (int k = 5; k <= 6; k++) begin
        q1_pipe[k]  <= q1_pipe[k-1];
        q1_fpipe[k] <= q1_fpipe[k-1];
      end
      short_pipe[SHORT_STAGE] <= short_c;
      for (int k = SHORT_STAGE + 1; k <= LAT_NORM; k++) begin
        short_pipe[k] <= short_pipe[k-1];
      end
      rsp <= out_c;
    end
  end

endmodule

// File: rtl/core/qau_qmul.sv
`timescale 1ns / 1ps
// Three-stage Hamilton product with rounding and saturation.
module qau_qmul import qau_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  logic  conj_b,
  input  quat_t a,
  input  quat_t b,
  output quat_t res,
  output logic  flag
);

  localparam logic signed [PW:0] RND = (PW+1)'(1) << (FB - 1);

  logic signed [PW-1:0] prod [4][4];
  logic [3:0][3:0]      neg;
  logic signed [AW-1:0] acc [4];
  logic signed [AW-1:0] acc_next [4];
  quat_t                res_next;
  logic                 flag_next;

  always_comb begin
    logic signed [PW:0]   pr;
    logic signed [AW-1:0] t;
    for (int r = 0; r < 4; r++) begin
      acc_next[r] = '0;
      for (int i = 0; i < 4; i++) begin
        pr = {prod[r][i][PW-1], prod[r][i]} + RND;
        t  = AW'(pr >>> FB);
        acc_next[r] = neg[r][i] ? acc_next[r] - t : acc_next[r] + t;
      end
    end
  end

  always_comb begin
    logic [DW:0] s;
    flag_next = 1'b0;
    for (int r = 0; r < 4; r++) begin
      s           = sat_acc(acc[r]);
      res_next[r] = s[DW-1:0];
      flag_next   = flag_next | s[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 4; i++) begin
          prod[r][i] <= $signed(a[i]) * $signed(b[2'(i ^ r)]);
          neg[r][i]  <= neg_term(2'(r), 2'(i)) ^ (conj_b && (i ^ r) != 0);
        end
      end
      acc  <= acc_next;
      res  <= res_next;
      flag <= flag_next;
    end
  end

endmodule

// File: rtl/core/qau_norm.sv
`timescale 1ns / 1ps
// Normalize and inverse datapath: squares, pipelined root, pipelined divide.
module qau_norm import qau_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  quat_t      a,
  input  logic       inv,
  output quat_t      res,
  output norm_stat_t stat
);

  typedef struct packed {
    logic [3:0][DW-1:0] mag;
    logic [3:0]         neg;
    logic               inv;
    logic [SW-1:0]      sum;
  } sq_side_t;

  typedef struct packed {
    logic [SW-1:0] den;
    logic [3:0]    neg;
    logic [3:0]    ovf;
    logic          zero;
  } dv_side_t;

  typedef logic [3:0][NW-1:0] rem4_t;
  typedef logic [3:0][QB-1:0] quo4_t;

  localparam logic [DW-1:0] ONE  = DW'(1) << FB;
  localparam logic [DW:0]   MAXP = {2'b00, {(DW-1){1'b1}}};
  localparam logic [DW:0]   MAXN = {2'b01, {(DW-1){1'b0}}};

  // Squares of the magnitudes.
  logic [3:0][DW-1:0] mag_c;
  logic [PW-1:0]      sq1 [4];
  logic [3:0][DW-1:0] mag1;
  logic [3:0]         neg1;
  logic               inv1;
  logic [SW-1:0]      sum_c;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = a[i][DW-1] ? -a[i] : a[i];
    end
    sum_c = SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]) + SW'(sq1[3]);
  end

  // Square root, one result bit per stage.
  logic [SW-1:0] sq_rem  [0:SQ_STEPS];
  logic [SW-1:0] sq_root [0:SQ_STEPS];
  sq_side_t      sq_sd   [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq1[i]  <= mag_c[i] * mag_c[i];
        mag1[i] <= mag_c[i];
        neg1[i] <= a[i][DW-1];
      end
      inv1           <= inv;
      sq_rem[0]      <= sum_c;
      sq_root[0]     <= '0;
      sq_sd[0].mag   <= mag1;
      sq_sd[0].neg   <= neg1;
      sq_sd[0].inv   <= inv1;
      sq_sd[0].sum   <= sum_c;
    end
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ_STEPS - 1 - g));
    logic [SW-1:0] trial;
    logic          ge;
    assign trial = sq_root[g] + BIT;
    assign ge    = sq_rem[g] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[g+1]  <= ge ? sq_rem[g] - trial : sq_rem[g];
        sq_root[g+1] <= ge ? (sq_root[g] >> 1) + BIT : sq_root[g] >> 1;
        sq_sd[g+1]   <= sq_sd[g];
      end
    end
  end

  // Divider setup: pick the divisor and catch quotients that cannot fit.
  rem4_t    dv_rem [0:QB];
  quo4_t    dv_q   [0:QB];
  dv_side_t dv_sd  [0:QB];
  rem4_t    init_rem;
  dv_side_t init_sd;

  always_comb begin
    sq_side_t sd;
    sd          = sq_sd[SQ_STEPS];
    init_sd.den = sd.inv ? sd.sum : sq_root[SQ_STEPS];
    init_sd.zero = sd.sum == '0;
    for (int i = 0; i < 4; i++) begin
      init_rem[i]    = sd.inv ? NW'(sd.mag[i]) << (2 * FB) : NW'(sd.mag[i]) << FB;
      init_sd.ovf[i] = TW'(init_rem[i]) >= (TW'(init_sd.den) << QB);
      init_sd.neg[i] = sd.neg[i] ^ (sd.inv && i != 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= init_rem;
      dv_q[0]   <= '0;
      dv_sd[0]  <= init_sd;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    localparam int K = QB - 1 - g;
    rem4_t rem_n;
    quo4_t q_n;
    always_comb begin
      logic [TW-1:0] trial;
      logic          ge;
      trial = TW'(dv_sd[g].den) << K;
      for (int i = 0; i < 4; i++) begin
        ge       = TW'(dv_rem[g][i]) >= trial;
        rem_n[i] = ge ? NW'(TW'(dv_rem[g][i]) - trial) : dv_rem[g][i];
        q_n[i]   = dv_q[g][i] | (ge ? QB'(1) << K : QB'(0));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[g+1] <= rem_n;
        dv_q[g+1]   <= q_n;
        dv_sd[g+1]  <= dv_sd[g];
      end
    end
  end

  // Round half up, then restore the sign and clamp.
  logic [3:0][DW:0] qr;
  dv_side_t         rd_sd;
  quat_t            fin_res;
  logic             fin_sat;

  always_comb begin
    logic [DW:0] nq;
    fin_sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      nq = -qr[i];
      if (rd_sd.zero) begin
        fin_res[i] = (i == 0) ? ONE : '0;
      end else if (rd_sd.neg[i]) begin
        if (rd_sd.ovf[i] || qr[i] > MAXN) begin
          fin_res[i] = {1'b1, {(DW-1){1'b0}}};
          fin_sat    = 1'b1;
        end else begin
          fin_res[i] = nq[DW-1:0];
        end
      end else begin
        if (rd_sd.ovf[i] || qr[i] > MAXP) begin
          fin_res[i] = {1'b0, {(DW-1){1'b1}}};
          fin_sat    = 1'b1;
        end else begin
          fin_res[i] = qr[i][DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        qr[i] <= (DW+1)'(dv_q[QB][i]) +
                 (DW+1)'((TW'(dv_rem[QB][i]) << 1) >= TW'(dv_sd[QB].den));
      end
      rd_sd     <= dv_sd[QB];
      res       <= fin_res;
      stat.sat  <= fin_sat;
      stat.zero <= rd_sd.zero;
    end
  end

endmodule

// File: rtl/core/qau_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the quaternion unit and its bind to the top level.
module qau_chk import qau_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed or vanished");

  // The request side stalls exactly when a finished response is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    req_stall == (rsp_valid && rsp_stall))
    else $error("request stall does not follow response backpressure");

  // A zero norm answer is the identity quaternion; only its i, j and k parts are checked.
  a_zero_ident: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_ZERO |->
      rsp.res_x == '0 && rsp.res_y == '0 && rsp.res_z == '0)
    else $error("zero norm response is not the identity");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind quaternion_arithmetic_unit_core qau_chk u_qau_chk (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
